>>> hw/rtl/assert_macros.svh
// Shared assertion macros for the slot tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define TST_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond never holds outside reset.
`define TST_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`TST_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> hw/rtl/tst_pkg.sv
package tst_pkg;

	localparam int unsigned MAX_SLOTS = 8;
	localparam int unsigned DEF_SLOTS = 8;
	localparam int unsigned ID_W      = 8;
	localparam int unsigned VAL_W     = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned TMO_W     = 16;
	localparam int unsigned IDX_IN_W  = 3;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned DATA_W    = 64;

	localparam logic [TMO_W-1:0] DEF_TIMEOUT = 16'd3000;
	localparam logic [VAL_W-1:0] DEF_NO_DATA = 16'h8000;

	localparam logic [1:0] REG_SLOT_IDS = 2'd0;
	localparam logic [1:0] REG_NO_DATA  = 2'd1;
	localparam logic [1:0] REG_TIMEOUT  = 2'd2;

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_TICK   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_READ   = 2'd3
	} act_t;

	typedef struct packed {
		logic [DATA_W-1:0] slot_ids;
		logic [VAL_W-1:0]  no_data;
		logic [TMO_W-1:0]  timeout;
	} cfg_t;

	typedef struct packed {
		act_t                op;
		logic                walk;
		logic [ID_W-1:0]     sensor_id;
		logic [VAL_W-1:0]    value;
		logic [TIME_W-1:0]   now;
		logic [IDX_IN_W-1:0] slot_index;
	} cmd_t;

	typedef struct packed {
		logic [VAL_W-1:0] cur;
		logic [VAL_W-1:0] last;
		logic [VAL_W-1:0] maxv;
		logic [VAL_W-1:0] minv;
		logic [CNT_W-1:0] matched;
	} res_t;

endpackage

>>> hw/rtl/telemetry_slot_tracker.sv
// Telemetry slot tracker: keeps current, last valid, max, min and timestamp for each slot.
// Requests enter a two-entry queue and are run one at a time by the slot engine, which
// visits one slot per cycle: sample, tick and clear walk every slot in turn, a read visits
// only the slot that it names; results wait in a two-entry output queue, and the engine
// takes no new request while that queue is full. Registers are at byte
// addresses 0 (slot ids), 8 (no-data code) and 16 (timeout); write them only while idle.
module telemetry_slot_tracker #(
	parameter int unsigned SLOTS = tst_pkg::DEF_SLOTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tst_pkg::ADDR_W-1:0]          paddr,
	input  logic [tst_pkg::DATA_W-1:0]          pwdata,
	output logic [tst_pkg::DATA_W-1:0]          prdata,
	output logic                                pready,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          action,
	input  logic [tst_pkg::ID_W-1:0]            sensor_id,
	input  logic signed [tst_pkg::VAL_W-1:0]    sample_value,
	input  logic [tst_pkg::TIME_W-1:0]          now_ms,
	input  logic [tst_pkg::IDX_IN_W-1:0]        slot_index,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [tst_pkg::VAL_W-1:0]    current_value,
	output logic signed [tst_pkg::VAL_W-1:0]    last_value,
	output logic signed [tst_pkg::VAL_W-1:0]    max_value,
	output logic signed [tst_pkg::VAL_W-1:0]    min_value,
	output logic [tst_pkg::CNT_W-1:0]           matched_slots
);
	import tst_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	res_t res;
	logic cmd_valid;
	logic cmd_take;

	tst_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tst_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.sensor_id    (sensor_id),
		.sample_value (sample_value),
		.now_ms       (now_ms),
		.slot_index   (slot_index),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	tst_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign current_value = res.cur;
	assign last_value    = res.last;
	assign max_value     = res.maxv;
	assign min_value     = res.minv;
	assign matched_slots = res.matched;

endmodule

>>> hw/rtl/tst_cfg.sv
module tst_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tst_pkg::ADDR_W-1:0] paddr,
	input  logic [tst_pkg::DATA_W-1:0] pwdata,
	output logic [tst_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output tst_pkg::cfg_t              cfg
);
	import tst_pkg::*;

	logic [DATA_W-1:0] slot_ids_q;
	logic [VAL_W-1:0]  no_data_q;
	logic [TMO_W-1:0]  timeout_q;
	logic [1:0]        sel;
	logic              wr;

	assign pready = 1'b1;
	assign sel    = paddr[ADDR_W-1:ADDR_W-2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ids_q <= '0;
			no_data_q  <= DEF_NO_DATA;
			timeout_q  <= DEF_TIMEOUT;
		end else if (wr) begin
			unique case (sel)
				REG_SLOT_IDS: slot_ids_q <= pwdata;
				REG_NO_DATA:  no_data_q  <= pwdata[VAL_W-1:0];
				REG_TIMEOUT:  timeout_q  <= pwdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_SLOT_IDS: prdata = slot_ids_q;
			REG_NO_DATA:  prdata = {{(DATA_W-VAL_W){1'b0}}, no_data_q};
			REG_TIMEOUT:  prdata = {{(DATA_W-TMO_W){1'b0}}, timeout_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.slot_ids = slot_ids_q;
	assign cfg.no_data  = no_data_q;
	assign cfg.timeout  = timeout_q;

endmodule

>>> hw/rtl/tst_front.sv
module tst_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   action,
	input  logic [tst_pkg::ID_W-1:0]     sensor_id,
	input  logic [tst_pkg::VAL_W-1:0]    sample_value,
	input  logic [tst_pkg::TIME_W-1:0]   now_ms,
	input  logic [tst_pkg::IDX_IN_W-1:0] slot_index,
	output logic                         cmd_valid,
	output tst_pkg::cmd_t                cmd,
	input  logic                         cmd_take
);
	import tst_pkg::*;

	cmd_t       mem_q [2];
	cmd_t       req;
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       acc;

	// classify the request
	always_comb begin
		req.op         = act_t'(action);
		req.walk       = act_t'(action) != ACT_READ;
		req.sensor_id  = sensor_id;
		req.value      = sample_value;
		req.now        = now_ms;
		req.slot_index = slot_index;
	end

	assign full      = cnt_q == 2'd2;
	assign acc       = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				wr_q <= !wr_q;
			end
			if (cmd_take) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(acc) - 2'(cmd_take);
		end
	end

endmodule

>>> hw/rtl/tst_back.sv
`include "assert_macros.svh"

module tst_back #(
	parameter int unsigned SLOTS = tst_pkg::DEF_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tst_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  tst_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          empty,
	input  logic          pop,
	output tst_pkg::res_t res
);
	import tst_pkg::*;

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} st_t;

	st_t               state_q;
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  match_cnt_q;

	logic [VAL_W-1:0]  cur_q   [SLOTS];
	logic [VAL_W-1:0]  last_q  [SLOTS];
	logic [VAL_W-1:0]  max_q   [SLOTS];
	logic [VAL_W-1:0]  min_q   [SLOTS];
	logic [TIME_W-1:0] stamp_q [SLOTS];

	res_t              res_mem_q [2];
	logic              res_wr_q;
	logic              res_rd_q;
	logic [1:0]        res_cnt_q;

	logic [VAL_W-1:0]  cur;
	logic [VAL_W-1:0]  lst;
	logic [VAL_W-1:0]  mx;
	logic [VAL_W-1:0]  mn;
	logic [TIME_W-1:0] stamp;
	logic [ID_W-1:0]   slot_id;
	logic [TIME_W-1:0] age;
	logic              hit;
	logic              expired;
	logic              cur_live;
	logic              max_upd;
	logic              min_upd;
	logic              in_range;
	logic              running;
	logic              done;
	logic [CNT_W-1:0]  matched_next;
	logic              res_push;
	logic              res_pop;
	res_t              res_in;

	assign running  = state_q == ST_RUN;
	assign cmd_take = state_q == ST_IDLE && cmd_valid && res_cnt_q != 2'd2;

	assign cur      = cur_q[idx_q];
	assign lst      = last_q[idx_q];
	assign mx       = max_q[idx_q];
	assign mn       = min_q[idx_q];
	assign stamp    = stamp_q[idx_q];
	assign slot_id  = cfg.slot_ids[{idx_q, 3'b000} +: ID_W];
	assign hit      = slot_id == cmd_q.sensor_id;
	assign age      = cmd_q.now - stamp;
	assign expired  = age > {{(TIME_W-TMO_W){1'b0}}, cfg.timeout};
	assign cur_live = cur != cfg.no_data;
	assign max_upd  = cur_live && (mx == cfg.no_data || $signed(cur) > $signed(mx));
	assign min_upd  = cur_live && (mn == cfg.no_data || $signed(cur) < $signed(mn));
	assign in_range = {1'b0, cmd_q.slot_index} < CNT_W'(SLOTS);
	assign done     = running && (!cmd_q.walk || idx_q == LAST_IDX);

	assign matched_next = match_cnt_q + CNT_W'(hit && cmd_q.op == ACT_SAMPLE);

	always_comb begin
		res_in = '0;
		if (cmd_q.op == ACT_READ) begin
			if (in_range) begin
				res_in.cur  = cur;
				res_in.last = lst;
				res_in.maxv = mx;
				res_in.minv = mn;
			end else begin
				res_in.cur  = cfg.no_data;
				res_in.last = cfg.no_data;
				res_in.maxv = cfg.no_data;
				res_in.minv = cfg.no_data;
			end
		end
		if (cmd_q.op == ACT_SAMPLE) begin
			res_in.matched = matched_next;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			match_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						state_q     <= ST_RUN;
						idx_q       <= cmd.walk ? '0 : cmd.slot_index[IDX_W-1:0];
						match_cnt_q <= '0;
					end
				end
				ST_RUN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q       <= idx_q + IDX_W'(1);
						match_cnt_q <= matched_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
	end

	// slot records
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				cur_q[i]   <= DEF_NO_DATA;
				last_q[i]  <= DEF_NO_DATA;
				max_q[i]   <= DEF_NO_DATA;
				min_q[i]   <= DEF_NO_DATA;
				stamp_q[i] <= '0;
			end
		end else if (running) begin
			case (cmd_q.op)
				ACT_SAMPLE: begin
					if (hit) begin
						cur_q[idx_q] <= cmd_q.value;
						if (cmd_q.value != cfg.no_data) begin
							last_q[idx_q]  <= cmd_q.value;
							stamp_q[idx_q] <= cmd_q.now;
						end
					end
				end
				ACT_TICK: begin
					if (max_upd) begin
						max_q[idx_q] <= cur;
					end
					if (min_upd) begin
						min_q[idx_q] <= cur;
					end
					if (expired) begin
						cur_q[idx_q] <= cfg.no_data;
					end
				end
				ACT_CLEAR: begin
					cur_q[idx_q]   <= cfg.no_data;
					last_q[idx_q]  <= cfg.no_data;
					max_q[idx_q]   <= cfg.no_data;
					min_q[idx_q]   <= cfg.no_data;
					stamp_q[idx_q] <= cmd_q.now;
				end
				default: ;
			endcase
		end
	end

	// result queue
	assign res_push = done;
	assign empty    = res_cnt_q == 2'd0;
	assign res_pop  = pop && !empty;
	assign res      = res_mem_q[res_rd_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= !res_rd_q;
			end
			res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);
		end
	end

	`TST_ASSERT(a_take_runs, clk, arst_n, cmd_take |=> state_q == ST_RUN, "take did not start run")
	`TST_ASSERT(a_push_idles, clk, arst_n, res_push |=> state_q == ST_IDLE, "push did not end run")
	`TST_ASSERT_NEVER(a_res_ovf, clk, arst_n, res_push && !res_pop && res_cnt_q == 2'd2, "result overflow")
	`TST_ASSERT(a_match_zero, clk, arst_n, res_push && cmd_q.op != ACT_SAMPLE |-> res_in.matched == '0, "count on non-sample")

endmodule
